// ===== rtl/dstq_pkg.sv =====
package dstq_pkg;

  // Queue geometry and field widths
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;
  localparam int ID_BITS     = 8;
  localparam int ELAPSED_BITS = 16;
  localparam int DELAY_BITS  = 32;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int NCNT_BITS   = $clog2(MAX_RESULTS + 1);

  // Request codes
  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_UPDATE   = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [ID_BITS-1:0]      task_id;
    logic [DELAY_BITS-1:0]   delay;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] fired_id;
    logic               fired;
    logic               status;
    logic               queue_empty;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [ID_BITS-1:0]   task_id;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [PTR_BITS-1:0] addr;
    entry_t              data;
  } mem_wr_t;

  typedef struct packed {
    logic                re;
    logic [PTR_BITS-1:0] addr;
  } mem_rd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEADLINE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_UPD_RD,
    S_UPD_CMP,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/deadline_sorted_timer_queue.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i  (dstq_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i| out_data_o (dstq_pkg::out_item_t)
//
// A schedule forms the deadline, then reads each entry with an equal or later deadline and
// moves it up a slot until an earlier entry stops the scan, then writes the new entry. An
// update pops each due head entry until one not yet due, an empty queue or the result limit
// ends the walk. One read port, one write port and one shared add/compare unit set this order.
// A full queue or an empty update goes straight to its result. Reset clears the time counter,
// fill count and head/tail pointers, not the entry memory; a stalled output holds the walk.
module deadline_sorted_timer_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dstq_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dstq_pkg::out_item_t out_data_o
);
  import dstq_pkg::*;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
    ptr_dec = (p == '0) ? PTR_BITS'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [CNT_BITS-1:0]  scan_q, scan_d;
  logic [PTR_BITS-1:0]  head_q, head_d;
  logic [PTR_BITS-1:0]  tail_q, tail_d;
  logic [PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [NCNT_BITS-1:0] n_q, n_d;
  logic [ID_BITS-1:0]   task_q, task_d;
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  logic [ID_BITS-1:0]   res_id_q, res_id_d;
  logic                 res_fired_q, res_fired_d;
  logic                 res_status_q, res_status_d;

  logic                 out_valid_q;
  out_item_t            out_q;
  logic                 load_out;
  out_item_t            load_item;
  logic                 slot_free;

  logic [TIME_BITS-1:0] op_a, op_b, alu_sum;
  logic                 alu_lt;

  mem_wr_t              mem_wr;
  mem_rd_t              mem_rd;
  entry_t               rd_entry;

  dstq_alu u_alu (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .sum_o  (alu_sum),
    .lt_o   (alu_lt)
  );

  dstq_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (rd_entry)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: operand selection, memory control and result staging.
  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    dl_d         = dl_q;
    count_d      = count_q;
    scan_d       = scan_q;
    head_d       = head_q;
    tail_d       = tail_q;
    wr_ptr_d     = wr_ptr_q;
    n_d          = n_q;
    task_d       = task_q;
    delay_d      = delay_q;
    res_id_d     = res_id_q;
    res_fired_d  = res_fired_q;
    res_status_d = res_status_q;
    load_out     = 1'b0;
    load_item    = '0;
    op_a         = now_q;
    op_b         = '0;
    mem_wr       = '0;
    mem_rd       = '0;

    case (state_q)
      S_IDLE: begin
        op_b = {{(TIME_BITS - ELAPSED_BITS){1'b0}}, in_data_i.elapsed};
        if (in_valid_i) begin
          now_d        = alu_sum;
          task_d       = in_data_i.task_id;
          delay_d      = in_data_i.delay;
          res_id_d     = '0;
          res_fired_d  = 1'b0;
          res_status_d = 1'b0;
          n_d          = '0;
          if (in_data_i.req_type == REQ_SCHEDULE) begin
            if (count_q == CNT_BITS'(QUEUE_DEPTH)) begin
              res_status_d = 1'b1;
              state_d      = S_EMIT;
            end else begin
              state_d = S_DEADLINE;
            end
          end else if (count_q == '0) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_UPD_RD;
          end
        end
      end

      // Deadline of the new entry; the scan starts at the tail.
      S_DEADLINE: begin
        op_b     = {{(TIME_BITS - DELAY_BITS){1'b0}}, delay_q};
        dl_d     = alu_sum;
        scan_d   = count_q;
        wr_ptr_d = tail_q;
        state_d  = (count_q == '0) ? S_INS_PUT : S_INS_RD;
      end

      S_INS_RD: begin
        mem_rd.re   = 1'b1;
        mem_rd.addr = ptr_dec(wr_ptr_q);
        state_d     = S_INS_CMP;
      end

      // An earlier deadline stops the scan; otherwise the entry moves up.
      S_INS_CMP: begin
        op_a = rd_entry.deadline;
        op_b = dl_q;
        if (alu_lt) begin
          state_d = S_INS_PUT;
        end else begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = wr_ptr_q;
          mem_wr.data = rd_entry;
          wr_ptr_d    = ptr_dec(wr_ptr_q);
          scan_d      = scan_q - 1'b1;
          state_d     = (scan_q == CNT_BITS'(1)) ? S_INS_PUT : S_INS_RD;
        end
      end

      S_INS_PUT: begin
        mem_wr.we            = 1'b1;
        mem_wr.addr          = wr_ptr_q;
        mem_wr.data.deadline = dl_q;
        mem_wr.data.task_id  = task_q;
        tail_d               = ptr_inc(tail_q);
        count_d              = count_q + 1'b1;
        state_d              = S_EMIT;
      end

      S_UPD_RD: begin
        mem_rd.re   = 1'b1;
        mem_rd.addr = head_q;
        state_d     = S_UPD_CMP;
      end

      // A due head entry is popped; the one held before it goes out as not last.
      S_UPD_CMP: begin
        op_b = rd_entry.deadline;
        if (alu_lt) begin
          state_d = S_EMIT;
        end else if (!res_fired_q || slot_free) begin
          if (res_fired_q) begin
            load_out              = 1'b1;
            load_item.fired_id    = res_id_q;
            load_item.fired       = 1'b1;
            load_item.queue_empty = (count_q == '0);
          end
          res_id_d    = rd_entry.task_id;
          res_fired_d = 1'b1;
          head_d      = ptr_inc(head_q);
          count_d     = count_q - 1'b1;
          n_d         = n_q + 1'b1;
          if (count_q == CNT_BITS'(1) || n_d == NCNT_BITS'(MAX_RESULTS)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_UPD_RD;
          end
        end
      end

      // Final result of the item.
      S_EMIT: begin
        if (slot_free) begin
          load_out              = 1'b1;
          load_item.fired_id    = res_id_q;
          load_item.fired       = res_fired_q;
          load_item.status      = res_status_q;
          load_item.queue_empty = (count_q == '0);
          load_item.last        = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    dl_q         <= dl_d;
    scan_q       <= scan_d;
    wr_ptr_q     <= wr_ptr_d;
    n_q          <= n_d;
    task_q       <= task_d;
    delay_q      <= delay_d;
    res_id_q     <= res_id_d;
    res_fired_q  <= res_fired_d;
    res_status_q <= res_status_d;
  end

  // Output register: a result waits here until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= load_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/dstq_alu.sv =====
module dstq_alu (
  input  logic [dstq_pkg::TIME_BITS-1:0] op_a_i,
  input  logic [dstq_pkg::TIME_BITS-1:0] op_b_i,
  output logic [dstq_pkg::TIME_BITS-1:0] sum_o,
  output logic                           lt_o
);
  import dstq_pkg::*;

  logic [TIME_BITS:0] sum_full;

  // Saturating add: a carry out clamps the result to the largest time value.
  assign sum_full = {1'b0, op_a_i} + {1'b0, op_b_i};
  assign sum_o    = sum_full[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];

  // Unsigned magnitude compare.
  assign lt_o = (op_a_i < op_b_i);

endmodule

// ===== rtl/dstq_mem.sv =====
module dstq_mem (
  input  logic              clk_i,
  input  dstq_pkg::mem_wr_t wr_i,
  input  dstq_pkg::mem_rd_t rd_i,
  output dstq_pkg::entry_t  rd_data_o
);
  import dstq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_data_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dstq_checker.sv =====
module dstq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input dstq_pkg::out_item_t out_data_o,
  input logic                out_valid_o,
  input logic                out_ready_i
);
  import dstq_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A rejected schedule carries no task and closes its item.
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> !out_data_o.fired && out_data_o.last)
    else $error("full status on a fired or non-final result");

  // A result without a task is always the only result of its item.
  a_unfired_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fired |-> out_data_o.last && out_data_o.fired_id == '0)
    else $error("unfired result not final or with an id");

  // A result that is not final is followed by more results of the same item.
  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |-> !in_ready_o)
    else $error("input taken while an update still emits");

endmodule

bind deadline_sorted_timer_queue dstq_checker u_dstq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);
